@@ hdl/glct_pkg.sv @@
// ----------------------------------------------------------------------------
// glct_pkg: shared constants for the grid line cell traversal
// sizes of the fixed-point grid coordinates, walk counters and decision error
// ----------------------------------------------------------------------------
package glct_pkg;

    localparam int CELL_BITS = 5;
    localparam int FRAC_BITS = 8;
    localparam int COORD_W   = CELL_BITS + FRAC_BITS;
    localparam int RUN_W     = CELL_BITS + 1;
    localparam int FACT_W    = FRAC_BITS + 1;
    localparam int PROD_W    = COORD_W + FACT_W;
    localparam int ERR_W     = PROD_W + 2;

    localparam logic [FACT_W-1:0] FRAC_ONE = FACT_W'(1) << FRAC_BITS;

    // step direction codes
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_POS  = 2'd1;
    localparam logic [1:0] DIR_NEG  = 2'd3;

endpackage

@@ hdl/glct_if.sv @@
// ----------------------------------------------------------------------------
// glct_if: request channels of the grid line cell traversal
// segment channel into the block and cell channel out of it
// ----------------------------------------------------------------------------
interface glct_seg_if;
    logic                         valid;
    logic                         ready;
    logic [glct_pkg::COORD_W-1:0] start_x;
    logic [glct_pkg::COORD_W-1:0] start_y;
    logic [glct_pkg::COORD_W-1:0] end_x;
    logic [glct_pkg::COORD_W-1:0] end_y;

    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface glct_cell_if;
    logic                           valid;
    logic                           ready;
    logic [glct_pkg::CELL_BITS-1:0] cell_x;
    logic [glct_pkg::CELL_BITS-1:0] cell_y;
    logic                           last_cell;

    modport source (output valid, cell_x, cell_y, last_cell, input ready);
    modport sink   (input valid, cell_x, cell_y, last_cell, output ready);
endinterface

@@ hdl/grid_line_cell_traversal.sv @@
// ----------------------------------------------------------------------------
// grid_line_cell_traversal: cell walk of a segment over a unit grid
// setup: a taken segment passes S_MULX and S_MULY, then S_WALK registers
//   its first cell request; a segment yields N cells (N = 1..63), one cell
//   per cycle while the sink keeps up; a new segment waits for S_IDLE;
//   one shared multiplier and adder build the error, the adder steps the walk
// reset: synchronous active low, returns to idle with no request pending
// ----------------------------------------------------------------------------
module grid_line_cell_traversal (
    input  logic        i_clk,
    input  logic        i_rst_n,
    glct_seg_if.sink    i_seg,
    glct_cell_if.source o_cell
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MULX,
        S_MULY,
        S_WALK
    } t_state;

    t_state                           r_state;
    logic [glct_pkg::CELL_BITS-1:0]   r_walk_x, r_walk_y;
    logic signed [glct_pkg::ERR_W-1:0] r_err;
    logic [glct_pkg::RUN_W-1:0]       r_left;
    logic [glct_pkg::COORD_W-1:0]     r_span_x, r_span_y;
    logic [1:0]                       r_dir_x, r_dir_y;
    logic [glct_pkg::FRAC_BITS-1:0]   r_frac_x, r_frac_y;
    logic                             r_out_valid;
    logic [glct_pkg::CELL_BITS-1:0]   r_out_x, r_out_y;
    logic                             r_out_last;

    // setup from the incoming segment
    logic [glct_pkg::COORD_W-1:0]   n_span_x, n_span_y;
    logic [1:0]                     n_dir_x, n_dir_y;
    logic [glct_pkg::CELL_BITS-1:0] ca_x, ca_y, cb_x, cb_y, cd_x, cd_y;
    logic [glct_pkg::RUN_W-1:0]     n_run;

    // shared multiplier and adder
    logic [glct_pkg::FACT_W-1:0]       mul_fact;
    logic [glct_pkg::COORD_W-1:0]      mul_span;
    logic [1:0]                        mul_dir;
    logic [glct_pkg::FRAC_BITS-1:0]    mul_frac;
    logic [glct_pkg::PROD_W-1:0]       mul_prod;
    logic signed [glct_pkg::ERR_W-1:0] add_a, add_b, add_sum;
    logic                              add_sub;

    logic seg_take, out_load, spans_nz, step_y;

    assign seg_take = i_seg.valid && i_seg.ready;
    assign out_load = (r_state == S_WALK) && (!r_out_valid || o_cell.ready);
    assign spans_nz = (r_span_x != '0) && (r_span_y != '0);

    always_comb begin
        ca_x = i_seg.start_x[glct_pkg::COORD_W-1:glct_pkg::FRAC_BITS];
        ca_y = i_seg.start_y[glct_pkg::COORD_W-1:glct_pkg::FRAC_BITS];
        cb_x = i_seg.end_x[glct_pkg::COORD_W-1:glct_pkg::FRAC_BITS];
        cb_y = i_seg.end_y[glct_pkg::COORD_W-1:glct_pkg::FRAC_BITS];
        if (i_seg.end_x > i_seg.start_x) begin
            n_dir_x  = glct_pkg::DIR_POS;
            n_span_x = i_seg.end_x - i_seg.start_x;
            cd_x     = cb_x - ca_x;
        end else if (i_seg.end_x < i_seg.start_x) begin
            n_dir_x  = glct_pkg::DIR_NEG;
            n_span_x = i_seg.start_x - i_seg.end_x;
            cd_x     = ca_x - cb_x;
        end else begin
            n_dir_x  = glct_pkg::DIR_NONE;
            n_span_x = '0;
            cd_x     = '0;
        end
        if (i_seg.end_y > i_seg.start_y) begin
            n_dir_y  = glct_pkg::DIR_POS;
            n_span_y = i_seg.end_y - i_seg.start_y;
            cd_y     = cb_y - ca_y;
        end else if (i_seg.end_y < i_seg.start_y) begin
            n_dir_y  = glct_pkg::DIR_NEG;
            n_span_y = i_seg.start_y - i_seg.end_y;
            cd_y     = ca_y - cb_y;
        end else begin
            n_dir_y  = glct_pkg::DIR_NONE;
            n_span_y = '0;
            cd_y     = '0;
        end
        n_run = glct_pkg::RUN_W'(1) + glct_pkg::RUN_W'(cd_x) + glct_pkg::RUN_W'(cd_y);
    end

    // x part uses the y span, y part uses the x span
    always_comb begin
        if (r_state == S_MULX) begin
            mul_dir  = r_dir_x;
            mul_frac = r_frac_x;
            mul_span = r_span_y;
        end else begin
            mul_dir  = r_dir_y;
            mul_frac = r_frac_y;
            mul_span = r_span_x;
        end
        case (mul_dir)
            glct_pkg::DIR_POS: mul_fact = glct_pkg::FRAC_ONE - glct_pkg::FACT_W'(mul_frac);
            glct_pkg::DIR_NEG: mul_fact = glct_pkg::FACT_W'(mul_frac);
            default:           mul_fact = '0;
        endcase
        mul_prod = glct_pkg::PROD_W'(mul_fact) * glct_pkg::PROD_W'(mul_span);
    end

    // error > 0 moves y, otherwise x; flat spans force the axis
    always_comb begin
        if (r_span_x == '0) begin
            step_y = 1'b1;
        end else if (r_span_y == '0) begin
            step_y = 1'b0;
        end else begin
            step_y = (r_err > 0);
        end
    end

    always_comb begin
        add_a = r_err;
        if (r_state == S_MULY) begin
            add_sub = 1'b1;
            add_b   = glct_pkg::ERR_W'(mul_prod);
        end else begin
            add_sub = step_y;
            add_b   = step_y
                    ? glct_pkg::ERR_W'({r_span_x, {glct_pkg::FRAC_BITS{1'b0}}})
                    : glct_pkg::ERR_W'({r_span_y, {glct_pkg::FRAC_BITS{1'b0}}});
        end
        add_sum = add_sub ? (add_a - add_b) : (add_a + add_b);
    end

    function automatic logic [glct_pkg::CELL_BITS-1:0] move_cell(
        input logic [glct_pkg::CELL_BITS-1:0] pos,
        input logic [1:0]                     dir
    );
        logic [glct_pkg::CELL_BITS-1:0] res;
        case (dir)
            glct_pkg::DIR_POS: res = pos + glct_pkg::CELL_BITS'(1);
            glct_pkg::DIR_NEG: res = pos - glct_pkg::CELL_BITS'(1);
            default:           res = pos;
        endcase
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_left      <= '0;
            r_walk_x    <= '0;
            r_walk_y    <= '0;
            r_err       <= '0;
            r_span_x    <= '0;
            r_span_y    <= '0;
            r_dir_x     <= glct_pkg::DIR_NONE;
            r_dir_y     <= glct_pkg::DIR_NONE;
            r_frac_x    <= '0;
            r_frac_y    <= '0;
            r_out_x     <= '0;
            r_out_y     <= '0;
            r_out_last  <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_cell.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (seg_take) begin
                        r_span_x <= n_span_x;
                        r_span_y <= n_span_y;
                        r_dir_x  <= n_dir_x;
                        r_dir_y  <= n_dir_y;
                        r_walk_x <= ca_x;
                        r_walk_y <= ca_y;
                        r_frac_x <= i_seg.start_x[glct_pkg::FRAC_BITS-1:0];
                        r_frac_y <= i_seg.start_y[glct_pkg::FRAC_BITS-1:0];
                        r_left   <= n_run;
                        r_state  <= S_MULX;
                    end
                end
                S_MULX: begin
                    r_err   <= glct_pkg::ERR_W'(mul_prod);
                    r_state <= S_MULY;
                end
                S_MULY: begin
                    r_err   <= spans_nz ? add_sum : '0;
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    if (out_load) begin
                        r_out_x     <= r_walk_x;
                        r_out_y     <= r_walk_y;
                        r_out_last  <= (r_left == glct_pkg::RUN_W'(1));
                        r_left      <= r_left - glct_pkg::RUN_W'(1);
                        if (step_y) begin
                            r_walk_y <= move_cell(r_walk_y, r_dir_y);
                        end else begin
                            r_walk_x <= move_cell(r_walk_x, r_dir_x);
                        end
                        if (spans_nz) begin
                            r_err <= add_sum;
                        end
                        if (r_left == glct_pkg::RUN_W'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_seg.ready      = (r_state == S_IDLE);
    assign o_cell.valid     = r_out_valid;
    assign o_cell.cell_x    = r_out_x;
    assign o_cell.cell_y    = r_out_y;
    assign o_cell.last_cell = r_out_last;

`ifndef ASSERT_OFF
    a_walk_has_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_left != '0))
        else $error("walk running with no cells left");

    a_take_starts_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seg_take |=> (r_state == S_MULX))
        else $error("segment request did not start error setup");

    a_last_ends_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && (r_left == glct_pkg::RUN_W'(1))) |=>
            (r_state == S_IDLE && r_out_valid && r_out_last))
        else $error("final cell did not end the walk");

    a_flat_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && !spans_nz) |-> (r_err == '0))
        else $error("decision error moved on a flat segment");
`endif

endmodule
